FILE: rtl/core/slxfc_pkg.sv
`timescale 1ns / 1ps
// types and constants for the sync / length / xor frame checker
// no dependencies; imported by every module of the block

package slxfc_pkg;

   // one received byte of a packet
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // one verdict per packet
   typedef struct packed {
      logic        frame_ok;
      logic [2:0]  status;
      logic [15:0] type_code;
      logic [15:0] frame_length;
   } rsp_type;

   // verdict codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_SHORT     = 3'd1;
   localparam logic [2:0] STATUS_BAD_SYNC  = 3'd2;
   localparam logic [2:0] STATUS_BAD_LEN   = 3'd3;
   localparam logic [2:0] STATUS_BAD_CSUM  = 3'd4;

   // frame layout
   localparam logic [7:0]  SYNC_BYTE   = 8'hAA;
   localparam logic [15:0] POS_SYNC_A  = 16'd0;
   localparam logic [15:0] POS_SYNC_B  = 16'd1;
   localparam logic [15:0] POS_LEN_LO  = 16'd6;
   localparam logic [15:0] POS_LEN_HI  = 16'd7;
   localparam logic [15:0] POS_CSUM    = 16'd8;
   localparam logic [15:0] POS_TYPE_LO = 16'd9;
   localparam logic [15:0] POS_TYPE_HI = 16'd10;
   localparam logic [15:0] MIN_FRAME   = 16'd10;
   localparam logic [15:0] POS_MAX     = 16'hFFFF;

endpackage

FILE: rtl/core/slxfc_in_stage.sv
`timescale 1ns / 1ps
// input register of the frame checker: holds one accepted byte word
// depends on slxfc_pkg

module slxfc_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  slxfc_pkg::req_type req_word,
   input  logic             advance,
   output logic             held_valid,
   output slxfc_pkg::req_type held_word
);
   import slxfc_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type word_ff;
   logic    accept;

   // stall only while the held word cannot move on
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // occupancy of the register
   always_comb begin
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
      end
   end

   assign held_valid = valid_ff;
   assign held_word  = word_ff;

endmodule

FILE: rtl/core/slxfc_frame_track.sv
`timescale 1ns / 1ps
// per-frame state of the checker and the verdict logic on the final byte
// depends on slxfc_pkg

module slxfc_frame_track (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  slxfc_pkg::req_type word,
   output logic               verdict_valid,
   output slxfc_pkg::rsp_type verdict
);
   import slxfc_pkg::*;

   logic [15:0] pos_ff,      pos_in,      pos_next;
   logic        ovf_ff,      ovf_in,      ovf_next;
   logic        sync_ff,     sync_in,     sync_next;
   logic [15:0] len_ff,      len_in,      len_next;
   logic [7:0]  csum_ff,     csum_in,     csum_next;
   logic [7:0]  xor_ff,      xor_in,      xor_next;
   logic [15:0] type_ff,     type_in,     type_next;
   logic [7:0]  b;
   logic [2:0]  status;

   assign b = word.data_byte;

   // field capture by byte position
   always_comb begin
      sync_next = sync_ff;
      len_next  = len_ff;
      csum_next = csum_ff;
      type_next = type_ff;
      if ((pos_ff == POS_SYNC_A || pos_ff == POS_SYNC_B) && b != SYNC_BYTE) begin
         sync_next = 1'b0;
      end
      if (pos_ff == POS_LEN_LO) begin
         len_next[7:0] = b;
      end
      if (pos_ff == POS_LEN_HI) begin
         len_next[15:8] = b;
      end
      if (pos_ff == POS_CSUM) begin
         csum_next = b;
      end
      if (pos_ff == POS_TYPE_LO) begin
         type_next[7:0] = b;
      end
      if (pos_ff == POS_TYPE_HI) begin
         type_next[15:8] = b;
      end
   end

   // payload checksum and saturating byte count
   assign xor_next = (pos_ff >= POS_TYPE_LO) ? (xor_ff ^ b) : xor_ff;
   assign ovf_next = ovf_ff || (pos_ff == POS_MAX);
   assign pos_next = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 16'd1;

   // verdict, checks in priority order
   always_comb begin
      priority if (pos_next < MIN_FRAME) begin
         status = STATUS_SHORT;
      end else if (!sync_next) begin
         status = STATUS_BAD_SYNC;
      end else if (ovf_next || len_next != pos_next) begin
         status = STATUS_BAD_LEN;
      end else if (xor_next != csum_next) begin
         status = STATUS_BAD_CSUM;
      end else begin
         status = STATUS_OK;
      end
   end

   assign verdict_valid         = step && word.last_byte;
   assign verdict.frame_ok      = (status == STATUS_OK);
   assign verdict.status        = status;
   assign verdict.type_code     = type_next;
   assign verdict.frame_length  = pos_next;

   // next state: hold, advance, or start a new frame after the final byte
   always_comb begin
      pos_in  = pos_ff;
      ovf_in  = ovf_ff;
      sync_in = sync_ff;
      len_in  = len_ff;
      csum_in = csum_ff;
      xor_in  = xor_ff;
      type_in = type_ff;
      if (step) begin
         if (word.last_byte) begin
            pos_in  = '0;
            ovf_in  = 1'b0;
            sync_in = 1'b1;
            len_in  = '0;
            csum_in = '0;
            xor_in  = '0;
            type_in = '0;
         end else begin
            pos_in  = pos_next;
            ovf_in  = ovf_next;
            sync_in = sync_next;
            len_in  = len_next;
            csum_in = csum_next;
            xor_in  = xor_next;
            type_in = type_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         ovf_ff  <= 1'b0;
         sync_ff <= 1'b1;
         len_ff  <= '0;
         csum_ff <= '0;
         xor_ff  <= '0;
         type_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         ovf_ff  <= ovf_in;
         sync_ff <= sync_in;
         len_ff  <= len_in;
         csum_ff <= csum_in;
         xor_ff  <= xor_in;
         type_ff <= type_in;
      end
   end

`ifndef SYNTHESIS
   // overflow only once the count has saturated
   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (pos_ff == POS_MAX))
      else $error("count overflow without saturated position");

   // a verdict starts a fresh frame
   a_fresh_after_verdict: assert property (@(posedge clock) disable iff (reset)
      verdict_valid |=> (pos_ff == '0 && sync_ff && xor_ff == '0 && !ovf_ff))
      else $error("frame state not cleared after verdict");

   // short frames never reach the later checks
   a_short_status: assert property (@(posedge clock) disable iff (reset)
      (verdict_valid && pos_next < MIN_FRAME) |-> (verdict.status == STATUS_SHORT))
      else $error("short frame given wrong status");
`endif

endmodule

FILE: rtl/core/slxfc_out_stage.sv
`timescale 1ns / 1ps
// result register of the frame checker: holds one verdict word until taken
// depends on slxfc_pkg

module slxfc_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  slxfc_pkg::rsp_type load_word,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output slxfc_pkg::rsp_type rsp_word
);
   import slxfc_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type word_ff;

   // register can take a word when empty or being emptied this cycle
   assign room = !valid_ff || !rsp_stall;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

FILE: rtl/core/sync_length_xor_frame_checker_unit.sv
`timescale 1ns / 1ps
// Frame checker for sync / length / xor-checksum packets, one byte word per cycle.
// A packet arrives as byte words with last_byte marking its final byte; on that
// byte one verdict word is produced: the byte is held in the input register, then
// its verdict is loaded into the result register and presented from there, and
// the checker starts a new frame. Bytes are taken back to back at one per cycle;
// only a final byte waiting on a full, stalled result register holds the input
// off. Checks run in the order too short (under ten bytes), sync (bytes 0 and 1
// equal 0xAA), declared length (bytes 6 and 7, little-endian; a count past 65535
// always fails), then xor of bytes 9 onward against byte 8. type_code is bytes 9
// and 10, zero where absent.
// Depends on slxfc_pkg, slxfc_in_stage, slxfc_frame_track and slxfc_out_stage.

module sync_length_xor_frame_checker_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  slxfc_pkg::req_type req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output slxfc_pkg::rsp_type rsp_word
);
   import slxfc_pkg::*;

   logic    held_valid;
   req_type held_word;
   logic    advance;
   logic    room;
   logic    verdict_valid;
   rsp_type verdict;

   // a held byte moves on unless it needs the result register and that is full and stalled
   assign advance = held_valid && (!held_word.last_byte || room);

   slxfc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .advance    (advance),
      .held_valid (held_valid),
      .held_word  (held_word)
   );

   slxfc_frame_track u_frame_track (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .word          (held_word),
      .verdict_valid (verdict_valid),
      .verdict       (verdict)
   );

   slxfc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (verdict_valid),
      .load_word (verdict),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
